// ===== src/font_glyph_rle_decoder_assert.svh =====
`ifndef FONT_GLYPH_RLE_DECODER_ASSERT_SVH
`define FONT_GLYPH_RLE_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FGR_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fgr check failed");

// next-cycle implication, sampled on clk, off during reset
`define FGR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fgr check failed");

`endif

// ===== src/fgr_pkg.sv =====
package fgr_pkg;

    localparam int STORE_BYTES  = 1024;
    localparam int IDX_W        = $clog2(STORE_BYTES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int POS_W        = IDX_W + 4;
    localparam int REPEAT_LIMIT = 11;
    localparam int COUNT_BITS   = 6;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_PIXEL  = 2'd2
    } cmd_code_t;

    typedef enum logic [1:0] {
        DS_SINGLE = 2'd0,
        DS_REPEAT = 2'd1,
        DS_COUNT  = 2'd2
    } dec_state_t;

    typedef enum logic [1:0] {
        PH_SINGLE = 2'd0,
        PH_VALUE  = 2'd1,
        PH_RBIT   = 2'd2,
        PH_COUNT  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_PLAN  = 3'd1,
        S_FETCH = 3'd2,
        S_TAKE  = 3'd3,
        S_EMIT  = 3'd4
    } ctl_state_t;

    typedef struct packed {
        logic   clear;
        logic   append;
        logic   load;
        logic   count_dec;
        logic   fetch;
        logic   take;
        phase_t phase;
        logic   emit;
    } ctl_cmd_t;

    typedef struct packed {
        dec_state_t wst;
        logic       rbit;
        logic       rep_limit;
        logic       take_zero;
        logic       dec_zero;
        logic       out_free;
    } dp_status_t;

    function automatic logic [7:0] alpha2_lut(input logic [1:0] code);
        logic [7:0] a;
        case (code)
            2'd0:    a = 8'd0;
            2'd1:    a = 8'd85;
            2'd2:    a = 8'd170;
            default: a = 8'd255;
        endcase
        return a;
    endfunction

endpackage

// ===== src/fgr_cmd_if.sv =====
interface fgr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

// ===== src/fgr_pix_if.sv =====
interface fgr_pix_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_code;
    logic [7:0] pixel_alpha;
    logic       status;

    modport source (output valid, output pixel_code, output pixel_alpha, output status,
                    input ready);
    modport sink (input valid, input pixel_code, input pixel_alpha, input status,
                  output ready);
endinterface

// ===== src/fgr_ram.sv =====
module fgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== src/fgr_datapath.sv =====
module fgr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic [7:0]        data_byte,
    input  fgr_pkg::ctl_cmd_t cmd,
    output fgr_pkg::dp_status_t stat,
    input  logic              pix_ready,
    output logic              pix_valid,
    output logic [3:0]        pixel_code,
    output logic [7:0]        pixel_alpha,
    output logic              status
);
    import fgr_pkg::*;

    logic             depth_reg;
    logic [CNT_W-1:0] loaded_reg;
    logic [POS_W-1:0] pos_reg;
    logic [3:0]       prev_reg;
    logic [5:0]       cnt_reg;
    dec_state_t       st_reg;

    // working copy for the pixel in flight
    logic [POS_W-1:0] pos_w_reg;
    logic [3:0]       prev_w_reg;
    logic [5:0]       cnt_w_reg;
    dec_state_t       st_w_reg;
    logic [3:0]       ret_w_reg;
    logic             bad_w_reg;

    logic             out_valid_reg;
    logic [3:0]       code_reg;
    logic [7:0]       alpha_reg;
    logic             status_reg;

    logic [7:0]       rd_a;
    logic [7:0]       rd_b;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
    logic             ram_we;

    logic [15:0]      aligned;
    logic [2:0]       take_len;
    logic [5:0]       take_val;
    logic [3:0]       val4;
    logic [POS_W-1:0] pos_sum;
    logic [POS_W-1:0] limit;
    logic             bad_take;
    logic [5:0]       cnt_dec;
    logic [7:0]       alpha_next;

    assign ram_we  = cmd.append && (loaded_reg != CNT_W'(STORE_BYTES));
    assign raddr_a = pos_w_reg[IDX_W+2:3];
    assign raddr_b = raddr_a + IDX_W'(1);

    fgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (loaded_reg[IDX_W-1:0]),
        .wdata   (data_byte),
        .re      (cmd.fetch),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        aligned = {rd_a, rd_b} << pos_w_reg[2:0];
        case (cmd.phase)
            PH_RBIT:
            begin
                take_len = 3'd1;
                take_val = {5'd0, aligned[15]};
            end
            PH_COUNT:
            begin
                take_len = 3'(COUNT_BITS);
                take_val = aligned[15:10];
            end
            default:
            begin
                if (depth_reg)
                begin
                    take_len = 3'd4;
                    take_val = {2'd0, aligned[15:12]};
                end
                else
                begin
                    take_len = 3'd2;
                    take_val = {4'd0, aligned[15:14]};
                end
            end
        endcase
        val4     = take_val[3:0];
        pos_sum  = pos_w_reg + POS_W'(take_len);
        limit    = {loaded_reg, 3'b000};
        bad_take = pos_sum > limit;
        cnt_dec  = cnt_w_reg - 6'd1;
        alpha_next = depth_reg ? {ret_w_reg, ret_w_reg} : alpha2_lut(ret_w_reg[1:0]);
    end

    always_comb
    begin
        stat.wst       = st_w_reg;
        stat.rbit      = aligned[15];
        stat.rep_limit = (cnt_w_reg == 6'(REPEAT_LIMIT - 1));
        stat.take_zero = (take_val == 6'd0);
        stat.dec_zero  = (cnt_dec == 6'd0);
        stat.out_free  = !out_valid_reg || pix_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= 1'b1;
            loaded_reg    <= '0;
            pos_reg       <= '0;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            st_reg        <= DS_SINGLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                depth_reg <= cfg_wr_data;
            end
            if (cmd.clear)
            begin
                loaded_reg <= '0;
                pos_reg    <= '0;
                prev_reg   <= '0;
                cnt_reg    <= '0;
                st_reg     <= DS_SINGLE;
            end
            if (ram_we)
            begin
                loaded_reg <= loaded_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (!bad_w_reg)
                begin
                    pos_reg  <= pos_w_reg;
                    prev_reg <= prev_w_reg;
                    cnt_reg  <= cnt_w_reg;
                    st_reg   <= st_w_reg;
                end
            end
            else if (pix_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_w_reg  <= pos_reg;
            prev_w_reg <= prev_reg;
            cnt_w_reg  <= cnt_reg;
            st_w_reg   <= st_reg;
            ret_w_reg  <= prev_reg;
            bad_w_reg  <= 1'b0;
        end
        if (cmd.count_dec)
        begin
            cnt_w_reg <= cnt_dec;
            ret_w_reg <= prev_w_reg;
        end
        if (cmd.take)
        begin
            pos_w_reg <= pos_sum;
            bad_w_reg <= bad_w_reg | bad_take;
            case (cmd.phase)
                PH_SINGLE:
                begin
                    ret_w_reg  <= val4;
                    prev_w_reg <= val4;
                    if ((pos_w_reg != '0) && (prev_w_reg == val4))
                    begin
                        cnt_w_reg <= '0;
                        st_w_reg  <= DS_REPEAT;
                    end
                    else
                    begin
                        st_w_reg <= DS_SINGLE;
                    end
                end
                PH_VALUE:
                begin
                    ret_w_reg  <= val4;
                    prev_w_reg <= val4;
                    st_w_reg   <= DS_SINGLE;
                end
                PH_RBIT:
                begin
                    cnt_w_reg <= cnt_w_reg + 6'd1;
                    if (aligned[15])
                    begin
                        ret_w_reg <= prev_w_reg;
                    end
                end
                default:
                begin
                    cnt_w_reg <= take_val;
                    ret_w_reg <= prev_w_reg;
                    if (take_val != 6'd0)
                    begin
                        st_w_reg <= DS_COUNT;
                    end
                end
            endcase
        end
        if (cmd.emit)
        begin
            code_reg   <= bad_w_reg ? 4'd0 : ret_w_reg;
            alpha_reg  <= bad_w_reg ? 8'd0 : alpha_next;
            status_reg <= bad_w_reg;
        end
    end

    assign pix_valid   = out_valid_reg;
    assign pixel_code  = code_reg;
    assign pixel_alpha = alpha_reg;
    assign status      = status_reg;

endmodule

// ===== src/fgr_ctrl.sv =====
module fgr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic [1:0]          command,
    output logic                cmd_ready,
    input  fgr_pkg::dp_status_t stat,
    output fgr_pkg::ctl_cmd_t   cmd
);
    import fgr_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    phase_t     ph_reg;
    phase_t     ph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_SINGLE;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        cmd.phase  = ph_reg;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (command)
                        CMD_START:  cmd.clear  = 1'b1;
                        CMD_APPEND: cmd.append = 1'b1;
                        CMD_PIXEL:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_PLAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_PLAN:
            begin
                unique case (stat.wst)
                    DS_COUNT:
                    begin
                        cmd.count_dec = 1'b1;
                        if (stat.dec_zero)
                        begin
                            ph_next    = PH_VALUE;
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    DS_REPEAT:
                    begin
                        ph_next    = PH_RBIT;
                        state_next = S_FETCH;
                    end
                    default:
                    begin
                        ph_next    = PH_SINGLE;
                        state_next = S_FETCH;
                    end
                endcase
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_EMIT;
                unique case (ph_reg)
                    PH_RBIT:
                    begin
                        if (!stat.rbit)
                        begin
                            ph_next    = PH_VALUE;
                            state_next = S_FETCH;
                        end
                        else if (stat.rep_limit)
                        begin
                            ph_next    = PH_COUNT;
                            state_next = S_FETCH;
                        end
                    end
                    PH_COUNT:
                    begin
                        if (stat.take_zero)
                        begin
                            ph_next    = PH_VALUE;
                            state_next = S_FETCH;
                        end
                    end
                    default: ;
                endcase
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/font_glyph_rle_decoder.sv =====
// Start and append beats are taken in the idle state and give no result.
// Pixel beat, fresh value: plan, fetch, extract, then emit; the next beat waits for idle.
// Counted run repeat: plan, then emit. Repeat bit, 6-bit count and fresh value: a fetch
// and an extract each. A result not taken stalls the input.
// Reset (rst_n, async, low) clears decoder state and sets 4 bpp; the byte store is not
// cleared and needs no sweep, since bits at or past the loaded byte count mark a result short.
module font_glyph_rle_decoder (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    fgr_cmd_if.sink   cmd_ch,
    fgr_pix_if.source pix_ch
);
    import fgr_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t stat;
    logic       cmd_ready;
    logic       pix_valid;
    logic [3:0] pixel_code;
    logic [7:0] pixel_alpha;
    logic       status;

    fgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_ch.valid),
        .command   (cmd_ch.command),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fgr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_byte   (cmd_ch.data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .pix_ready   (pix_ch.ready),
        .pix_valid   (pix_valid),
        .pixel_code  (pixel_code),
        .pixel_alpha (pixel_alpha),
        .status      (status)
    );

    assign cmd_ch.ready       = cmd_ready;
    assign pix_ch.valid       = pix_valid;
    assign pix_ch.pixel_code  = pixel_code;
    assign pix_ch.pixel_alpha = pixel_alpha;
    assign pix_ch.status      = status;

endmodule

// ===== src/fgr_checker.sv =====
`include "font_glyph_rle_decoder_assert.svh"

module fgr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] command,
    input logic       pix_valid,
    input logic       pix_ready,
    input logic [3:0] pixel_code,
    input logic [7:0] pixel_alpha,
    input logic       status
);
    import fgr_pkg::*;

    // stalled result beat holds
    `FGR_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable({pixel_code, pixel_alpha, status}))

    // short-data result is all zero
    `FGR_ASSERT_NOW(a_short_zero, pix_valid && status, pixel_code == 4'd0 && pixel_alpha == 8'd0)

    // code zero always means transparent
    `FGR_ASSERT_NOW(a_zero_alpha, pix_valid && pixel_code == 4'd0, pixel_alpha == 8'd0)

    // a pixel beat occupies the decoder for the next cycle
    `FGR_ASSERT_NEXT(a_pix_busy, cmd_valid && cmd_ready && command == CMD_PIXEL, !cmd_ready)

    // start and append never produce a result beat
    `FGR_ASSERT_NEXT(a_no_spurious, cmd_valid && cmd_ready && command != CMD_PIXEL && !pix_valid, !pix_valid)

endmodule

bind font_glyph_rle_decoder fgr_checker u_fgr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_ch.valid),
    .cmd_ready   (cmd_ch.ready),
    .command     (cmd_ch.command),
    .pix_valid   (pix_ch.valid),
    .pix_ready   (pix_ch.ready),
    .pixel_code  (pix_ch.pixel_code),
    .pixel_alpha (pix_ch.pixel_alpha),
    .status      (pix_ch.status)
);

// ===== sim/font_glyph_rle_decoder_tb.sv =====
module font_glyph_rle_decoder_tb;
    import fgr_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         RAND_ITEMS    = 200;
    localparam int         PHASE_ITEMS   = 40;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         END_LIMIT     = 20000;
    localparam logic [7:0] ALPHA_2BPP [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

    typedef struct packed {
        logic [3:0] code;
        logic [7:0] alpha;
        logic       status;
    } pix_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       typed;
        pix_t       want;
    } dir_row_t;

    // typed rows: empty store, 0xFF stream start, repeat entry, short repeat bit
    localparam dir_row_t DIR_ROWS [27] = '{
        '{CMD_PIXEL,  8'h00, 1'b1, '{4'd0,  8'd0,   1'b1}},
        '{CMD_UNUSED, 8'hA5, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_APPEND, 8'hFF, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b1, '{4'd15, 8'd255, 1'b0}},
        '{CMD_PIXEL,  8'hFF, 1'b1, '{4'd15, 8'd255, 1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b1, '{4'd0,  8'd0,   1'b1}},
        '{CMD_START,  8'hFF, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_APPEND, 8'h55, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_APPEND, 8'hFF, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_APPEND, 8'hE1, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_APPEND, 8'h80, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}},
        '{CMD_PIXEL,  8'h00, 1'b0, '{4'd0,  8'd0,   1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic calm;

    fgr_cmd_if cmd_ch ();
    fgr_pix_if pix_ch ();

    font_glyph_rle_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_ch      (cmd_ch),
        .pix_ch      (pix_ch)
    );

    always #2 clk = ~clk;

    // decoder shadow state
    logic [7:0]  byte_store [STORE_BYTES];
    int unsigned n_loaded;
    int unsigned bit_pos;
    logic [3:0]  prev_val;
    logic [5:0]  run_cnt;
    dec_state_t  mode;
    logic        depth_4bpp;

    pix_t        pending_pixels [$];
    bit          stream_bits [$];
    logic [7:0]  glyph_bytes [$];
    pix_t        got;
    pix_t        want;

    int n_fail;
    int n_beats;
    int n_pixels;
    int n_short;
    int n_checked;
    int n_cfg;

    function automatic void clear_glyph();
        n_loaded = 0;
        bit_pos  = 0;
        prev_val = '0;
        run_cnt  = '0;
        mode     = DS_SINGLE;
    endfunction

    function automatic logic [5:0] pull_bits(inout int unsigned pos, input int unsigned len,
                                             inout bit short);
        logic [5:0]  v;
        int unsigned p;
        int unsigned i;
        logic        b;
        v = '0;
        for (i = 0; i < len; i++)
        begin
            p = pos + i;
            b = 1'b0;
            if (p >= n_loaded * 8)
                short = 1'b1;
            else
                b = byte_store[p >> 3][7 - (p & 7)];
            v = {v[4:0], b};
        end
        pos += len;
        return v;
    endfunction

    function automatic pix_t decode_pixel();
        int unsigned pos;
        int unsigned w;
        logic [3:0]  pv;
        logic [3:0]  val;
        logic [5:0]  cnt;
        dec_state_t  st;
        bit          short;
        bit          at_start;
        pix_t        r;
        pos   = bit_pos;
        pv    = prev_val;
        cnt   = run_cnt;
        st    = mode;
        w     = depth_4bpp ? 4 : 2;
        short = 1'b0;
        val   = '0;
        case (st)
            DS_REPEAT:
            begin
                cnt = cnt + 6'd1;
                if (pull_bits(pos, 1, short) == 6'd1)
                begin
                    val = pv;
                    if (cnt == 6'(REPEAT_LIMIT))
                    begin
                        cnt = pull_bits(pos, COUNT_BITS, short);
                        if (cnt != 6'd0)
                            st = DS_COUNT;
                        else
                        begin
                            val = 4'(pull_bits(pos, w, short));
                            pv  = val;
                            st  = DS_SINGLE;
                        end
                    end
                end
                else
                begin
                    val = 4'(pull_bits(pos, w, short));
                    pv  = val;
                    st  = DS_SINGLE;
                end
            end
            DS_COUNT:
            begin
                val = pv;
                cnt = cnt - 6'd1;
                if (cnt == 6'd0)
                begin
                    val = 4'(pull_bits(pos, w, short));
                    pv  = val;
                    st  = DS_SINGLE;
                end
            end
            default:
            begin
                at_start = (pos == 0);
                val = 4'(pull_bits(pos, w, short));
                if (!at_start && pv == val)
                begin
                    cnt = '0;
                    st  = DS_REPEAT;
                end
                else
                    st = DS_SINGLE;
                pv = val;
            end
        endcase
        if (short)
            r = '{4'd0, 8'd0, 1'b1};
        else
        begin
            bit_pos  = pos;
            prev_val = pv;
            run_cnt  = cnt;
            mode     = st;
            r.code   = val;
            r.alpha  = depth_4bpp ? {val, val} : ALPHA_2BPP[val[1:0]];
            r.status = 1'b0;
        end
        return r;
    endfunction

    function automatic void apply_beat(input logic [1:0] c, input logic [7:0] d,
                                       output bit has, output pix_t r);
        has = 1'b0;
        r   = '0;
        case (c)
            CMD_START:
                clear_glyph();
            CMD_APPEND:
                if (n_loaded < STORE_BYTES)
                begin
                    byte_store[n_loaded] = d;
                    n_loaded++;
                end
            CMD_PIXEL:
            begin
                r   = decode_pixel();
                has = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void push_field(input logic [5:0] v, input int w);
        int i;
        for (i = w - 1; i >= 0; i--)
            stream_bits.push_back(v[i]);
    endfunction

    // stream built from values, repeats, short and full runs, zero and nonzero counts
    function automatic void make_stream(input int nb);
        int         i;
        int         j;
        int         w;
        logic [5:0] v;
        logic [5:0] k;
        logic [7:0] b;
        stream_bits.delete();
        glyph_bytes.delete();
        w = depth_4bpp ? 4 : 2;
        while (stream_bits.size() < nb * 8)
        begin
            v = 6'($urandom_range(0, depth_4bpp ? 15 : 3));
            push_field(v, w);
            if ($urandom_range(0, 1) == 1)
            begin
                push_field(v, w);
                case ($urandom_range(0, 3))
                    0:
                        push_field(6'd0, 1);
                    1:
                    begin
                        repeat ($urandom_range(1, 10)) push_field(6'd1, 1);
                        push_field(6'd0, 1);
                    end
                    default:
                    begin
                        repeat (REPEAT_LIMIT) push_field(6'd1, 1);
                        if ($urandom_range(0, 2) == 0)
                            k = 6'd0;
                        else if ($urandom_range(0, 7) == 0)
                            k = 6'd63;
                        else
                            k = 6'($urandom_range(1, 6));
                        push_field(k, COUNT_BITS);
                    end
                endcase
            end
        end
        for (i = 0; i < nb; i++)
        begin
            b = '0;
            for (j = 0; j < 8; j++)
                b = {b[6:0], stream_bits[i * 8 + j]};
            glyph_bytes.push_back(b);
        end
    endfunction

    task automatic issue(input logic [1:0] c, input logic [7:0] d, input bit typed,
                         input pix_t typed_pix);
        pix_t pred;
        bit   has;
        if (!calm && $urandom_range(0, 99) < 31)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= c;
        cmd_ch.data_byte <= d;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        apply_beat(c, d, has, pred);
        if (c != CMD_UNUSED)
            n_beats++;
        if (has)
        begin
            pending_pixels.push_back(typed ? typed_pix : pred);
            n_pixels++;
            if (pred.status)
                n_short++;
        end
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_depth(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        depth_4bpp = v;
        n_cfg++;
    endtask

    task automatic run_glyph(input bit keep);
        int nb;
        int np;
        int i;
        int k;
        if (!keep)
            issue(CMD_START, 8'($urandom), 1'b0, '0);
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        np = nb * 2 + $urandom_range(0, 5);
        make_stream(nb);
        for (i = 0; i < nb; i++)
        begin
            issue(CMD_APPEND, glyph_bytes[i], 1'b0, '0);
            if ($urandom_range(0, 1) == 1)
            begin
                k = $urandom_range(0, 3);
                if (k > np)
                    k = np;
                repeat (k) issue(CMD_PIXEL, 8'($urandom), 1'b0, '0);
                np -= k;
            end
        end
        if ($urandom_range(0, 19) == 0)
            settle();
        repeat (np) issue(CMD_PIXEL, 8'($urandom), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got = '{pix_ch.pixel_code, pix_ch.pixel_alpha, pix_ch.status};
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel beat, expected none, got code %0d alpha %0d %s",
                         $time, got.code, got.alpha, $sformatf("status %0d", got.status));
                n_fail++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                n_checked++;
                if (got.code !== want.code)
                begin
                    $display("%0t: pixel_code expected %0d got %0d", $time, want.code, got.code);
                    n_fail++;
                end
                if (got.alpha !== want.alpha)
                begin
                    $display("%0t: pixel_alpha expected %0d got %0d", $time, want.alpha, got.alpha);
                    n_fail++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                    n_fail++;
                end
            end
        end
        pix_ch.ready <= rst_n && (calm || $urandom_range(0, 99) >= 31);
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int  i;
        int  phase;
        int  base;
        int  mark;
        int  wait_cyc;
        bit  keep;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 1'b0;
        calm             = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_START;
        cmd_ch.data_byte = 8'h00;
        pix_ch.ready     = 1'b0;
        n_fail    = 0;
        n_beats   = 0;
        n_pixels  = 0;
        n_short   = 0;
        n_checked = 0;
        n_cfg     = 0;
        clear_glyph();
        depth_4bpp = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 27; i++)
            issue(DIR_ROWS[i].cmd, DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        // fill past the store size; the surplus appends must be dropped
        settle();
        write_depth(1'b1);
        issue(CMD_START, 8'h00, 1'b0, '0);
        make_stream(STORE_BYTES + 6);
        for (i = 0; i < STORE_BYTES + 6; i++)
            issue(CMD_APPEND, glyph_bytes[i], 1'b0, '0);
        repeat (60) issue(CMD_PIXEL, 8'($urandom), 1'b0, '0);

        phase = 0;
        base  = n_beats;
        while (n_beats - base < RAND_ITEMS)
        begin
            settle();
            case (phase)
                0: write_depth(1'b0);
                1: write_depth(1'b1);
                default:
                    if ($urandom_range(0, 1) == 1)
                        write_depth(1'($urandom_range(0, 1)));
            endcase
            calm <= (phase == 2);
            keep = (phase != 0) && ($urandom_range(0, 99) < 35);
            mark = n_beats;
            while (n_beats - mark < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    run_glyph(keep);
                    keep = 1'b0;
                end
                else
                    repeat ($urandom_range(1, 8))
                        issue(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
            end
            phase++;
        end
        calm <= 1'b0;
        cmd_ch.valid <= 1'b0;

        wait_cyc = 0;
        while (pending_pixels.size() != 0 && wait_cyc < END_LIMIT)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        if (pending_pixels.size() != 0)
        begin
            $display("%0t: %0d pixel beats expected but never seen", $time,
                     pending_pixels.size());
            n_fail += pending_pixels.size();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d command beats with %0d depth writes; checked %0d pixel beats %s",
                 n_beats, n_cfg, n_checked, $sformatf("(%0d short).", n_short));
        $display("Covered both depths, counted runs, a full byte store and depth changes mid-glyph.");
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/fgr_pkg.sv
src/fgr_cmd_if.sv
src/fgr_pix_if.sv
src/fgr_ram.sv
src/fgr_datapath.sv
src/fgr_ctrl.sv
src/font_glyph_rle_decoder.sv
src/fgr_checker.sv
sim/font_glyph_rle_decoder_tb.sv
